// ===== hdl/tti_pkg.sv =====
// ----------------------------------------------------------------------------
// tti_pkg
// Shared types, codes and helpers of the trajectory table interpolator.
// ----------------------------------------------------------------------------
`default_nettype none

package tti_pkg;

  localparam int DEF_TABLE_DEPTH = 256;
  localparam int DEF_FRAC_BITS   = 16;

  // result status codes
  localparam logic [1:0] ST_OK      = 2'd0;
  localparam logic [1:0] ST_LIMIT   = 2'd1;
  localparam logic [1:0] ST_ZERODIV = 2'd2;

  // configuration register indexes
  localparam logic [1:0] REG_ENTRIES = 2'd0;
  localparam logic [1:0] REG_LIMIT   = 2'd1;

  // input item kinds
  localparam logic OPN_LOAD  = 1'b0;
  localparam logic OPN_QUERY = 1'b1;

  // one table entry as held in memory
  typedef struct packed {
    logic signed [31:0] offset;
    logic signed [31:0] tstamp;
    logic signed [31:0] position;
  } entry_t;

  // divider request and response
  typedef struct packed {
    logic               start;
    logic signed [63:0] num;
    logic signed [31:0] den;
  } div_req_t;

  typedef struct packed {
    logic               done;
    logic signed [31:0] quot;
  } div_rsp_t;

  typedef enum logic [3:0] {
    S_IDLE, S_SFIRST, S_SCAN, S_SLOPE, S_MUL, S_DGO, S_DWAIT,
    S_WALK, S_SEG, S_OUT
  } state_t;

  typedef enum logic [2:0] {
    OP_INIT, OP_SPEED, OP_ORATE, OP_PPOS, OP_POFF
  } op_t;

  // clamp a wide signed value to the signed 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [65:0] v);
    logic signed [31:0] r;
    if (v > 66'sh0_7FFF_FFFF) begin
      r = 32'sh7FFF_FFFF;
    end else if (v < -66'sh0_8000_0000) begin
      r = -32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

`default_nettype wire

// ===== hdl/tti_table.sv =====
// ----------------------------------------------------------------------------
// tti_table
// Trajectory point store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_table
  import tti_pkg::*;
#(
  parameter int DEPTH = DEF_TABLE_DEPTH,
  parameter int AW    = $clog2(DEF_TABLE_DEPTH)
) (
  input  wire logic          clk,
  input  wire logic          wr_en,
  input  wire logic [AW-1:0] wr_addr,
  input  wire entry_t        wr_data,
  input  wire logic [AW-1:0] rd_addr,
  output entry_t             rd_data
);

  entry_t mem [DEPTH];

  // write one entry
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read every cycle
  always_ff @(posedge clk) begin
    rd_data <= mem[rd_addr];
  end

endmodule

`default_nettype wire

// ===== hdl/tti_div.sv =====
// ----------------------------------------------------------------------------
// tti_div
// Signed 64 by 32 divider, one quotient bit a cycle, truncating toward zero,
// quotient saturated to 32 bits.
// ----------------------------------------------------------------------------
`default_nettype none

module tti_div
  import tti_pkg::*;
(
  input  wire logic     clk,
  input  wire logic     rst,
  input  wire div_req_t req,
  output div_rsp_t      rsp
);

  logic        busy;
  logic        done;
  logic [5:0]  cnt;
  logic [63:0] nmag;
  logic [31:0] dmag;
  logic [32:0] rem;
  logic [63:0] q;
  logic        neg;
  logic [32:0] rem_sh;
  logic        fits;

  assign rem_sh = {rem[31:0], nmag[63]};

  // control
  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 6'd1;
        if (cnt == 6'd63) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  // restoring shift-subtract datapath
  always_ff @(posedge clk) begin
    if (req.start) begin
      nmag <= req.num[63] ? 64'(-req.num) : 64'(req.num);
      dmag <= req.den[31] ? 32'(-req.den) : 32'(req.den);
      neg  <= req.num[63] ^ req.den[31];
      rem  <= '0;
      q    <= '0;
    end else if (busy) begin
      nmag <= {nmag[62:0], 1'b0};
      if (rem_sh >= {1'b0, dmag}) begin
        rem <= rem_sh - {1'b0, dmag};
        q   <= {q[62:0], 1'b1};
      end else begin
        rem <= rem_sh;
        q   <= {q[62:0], 1'b0};
      end
    end
  end

  // sign and saturate
  assign fits = (q[63:31] == '0);
  always_comb begin
    rsp.done = done;
    if (!fits) begin
      rsp.quot = neg ? -32'sh8000_0000 : 32'sh7FFF_FFFF;
    end else begin
      rsp.quot = neg ? -$signed(q[31:0]) : $signed(q[31:0]);
    end
  end

endmodule

`default_nettype wire

// ===== hdl/trajectory_table_interpolator.sv =====
// ----------------------------------------------------------------------------
// trajectory_table_interpolator
// Piecewise linear interpolation over a table of trajectory points.
// ----------------------------------------------------------------------------
// Channel  Dir  Handshake            Content
// s_       in   tvalid/tready        tdata: entry and query fields; tuser: kind
// m_       out  tvalid/tready        tdata: four Q16.16 results; tuser: status
// cfg_     in   valid/ready          index, data: register writes
//
// A load is written to the table when it is accepted. A query scans for the segment
// that holds its position (when none holds it, the scan restarts at entry zero and
// takes the first segment), then walks entries toward the horizon; each step reads
// one memory row, and each of the five divisions runs multiply, start, 64 quotient
// bits, done. A query at or beyond the length limit goes straight to the output.
// Reset clears control state only; table contents are undefined until loaded.
// A new item is taken once the previous query has moved its result to the
// output register; a stalled output holds the next result back.
// ----------------------------------------------------------------------------
`default_nettype none

module trajectory_table_interpolator
  import tti_pkg::*;
#(
  parameter int TABLE_DEPTH = DEF_TABLE_DEPTH,
  parameter int FRAC_BITS   = DEF_FRAC_BITS
) (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  output logic              s_tready,
  // entry_index, entry_position, entry_time, entry_offset,
  // query_position, query_horizon
  input  wire logic [167:0] s_tdata,
  // operation
  input  wire logic [0:0]   s_tuser,
  output logic              m_tvalid,
  input  wire logic         m_tready,
  // speed, predicted_position, offset_rate, predicted_offset
  output logic [127:0]      m_tdata,
  // status
  output logic [1:0]        m_tuser,
  input  wire logic         cfg_valid,
  output logic              cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_data
);

  localparam int AW = $clog2(TABLE_DEPTH);
  localparam logic signed [31:0] ONE = 32'sd1 <<< FRAC_BITS;

  state_t state, state_next;
  op_t    op;

  logic [8:0]  entries_in_use;
  logic [30:0] length_limit;

  logic [AW-1:0] ptr;
  logic [AW-1:0] nlast;
  logic [AW-1:0] rd_addr;
  logic          force_first;
  entry_t        prev, cur, rd_data, wr_data;
  logic          wr_en;

  logic signed [31:0] s_pos, h_val, tk, init_t, c_val;
  logic signed [31:0] q_speed, q_orate, q_ppos;
  logic signed [63:0] prod;
  logic signed [31:0] mul_a, mul_b;
  div_req_t           dreq;
  div_rsp_t           drsp;

  logic signed [31:0] diff_p, diff_t, diff_o, sdiff;
  logic signed [33:0] walk;
  logic               scan_hit, walk_go, in_acc, is_query, over_limit;
  logic [31:0]        n_clamp;

  logic [1:0]  res_status;
  logic [127:0] res_data;

  // input field views
  logic [7:0]         in_index;
  logic signed [31:0] in_qpos, in_qh;
  assign in_index = s_tdata[7:0];
  assign in_qpos  = s_tdata[135:104];
  assign in_qh    = s_tdata[167:136];
  assign wr_data  = '{offset: s_tdata[103:72], tstamp: s_tdata[71:40],
                      position: s_tdata[39:8]};

  assign s_tready  = (state == S_IDLE);
  assign cfg_ready = 1'b1;
  assign in_acc    = s_tvalid && s_tready;
  assign is_query  = (s_tuser[0] == OPN_QUERY);
  assign over_limit = (in_qpos >= $signed({1'b0, length_limit}));
  assign wr_en     = in_acc && !is_query && (32'(in_index) < 32'(TABLE_DEPTH));

  tti_table #(.DEPTH(TABLE_DEPTH), .AW(AW)) u_table (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (AW'(in_index)),
    .wr_data (wr_data),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  tti_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  // clamp entry count
  always_comb begin
    if (entries_in_use < 9'd2) begin
      n_clamp = 32'd2;
    end else if (32'(entries_in_use) > 32'(TABLE_DEPTH)) begin
      n_clamp = 32'(TABLE_DEPTH);
    end else begin
      n_clamp = 32'(entries_in_use);
    end
  end

  // segment differences and walk terms
  assign diff_p = sat32(66'(cur.position) - 66'(prev.position));
  assign diff_t = sat32(66'(cur.tstamp) - 66'(prev.tstamp));
  assign diff_o = sat32(66'(cur.offset) - 66'(prev.offset));
  assign sdiff  = sat32(66'(s_pos) - 66'(prev.position));
  assign walk   = 34'(cur.tstamp) - 34'(tk) - 34'(init_t);
  assign walk_go = (ptr < nlast) && (walk < 34'(h_val));
  assign scan_hit = force_first ||
                    ((s_pos >= prev.position) && (s_pos < rd_data.position));

  // multiplier operands
  always_comb begin
    case (op)
      OP_INIT:  begin mul_a = sdiff;  mul_b = diff_t; end
      OP_SPEED: begin mul_a = diff_p; mul_b = ONE;    end
      OP_ORATE: begin mul_a = diff_o; mul_b = ONE;    end
      OP_PPOS:  begin mul_a = diff_p; mul_b = c_val;  end
      default:  begin mul_a = diff_o; mul_b = c_val;  end
    endcase
  end

  always_comb begin
    dreq.start = (state == S_DGO);
    dreq.num   = prod;
    dreq.den   = (op == OP_INIT) ? diff_p : diff_t;
  end

  // read address
  always_comb begin
    unique case (state)
      S_IDLE:   rd_addr = '0;
      S_SFIRST: rd_addr = AW'(1);
      S_SCAN:   rd_addr = (!scan_hit && ptr == nlast) ? '0 : ptr + AW'(1);
      S_WALK:   rd_addr = ptr + AW'(2);
      default:  rd_addr = ptr + AW'(1);
    endcase
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (in_acc && is_query) begin
          state_next = over_limit ? S_OUT : S_SFIRST;
        end
      end
      S_SFIRST: state_next = S_SCAN;
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_SLOPE;
        end else if (ptr == nlast) begin
          state_next = S_SFIRST;
        end
      end
      S_SLOPE:  state_next = (diff_p == '0) ? S_OUT : S_MUL;
      S_MUL:    state_next = S_DGO;
      S_DGO:    state_next = S_DWAIT;
      S_DWAIT: begin
        if (drsp.done) begin
          if (op == OP_INIT) begin
            state_next = S_WALK;
          end else if (op == OP_POFF) begin
            state_next = S_OUT;
          end else begin
            state_next = S_MUL;
          end
        end
      end
      S_WALK:   state_next = walk_go ? S_WALK : S_SEG;
      S_SEG:    state_next = (diff_t == '0) ? S_OUT : S_MUL;
      S_OUT:    state_next = (!m_tvalid || m_tready) ? S_IDLE : S_OUT;
      default:  state_next = S_IDLE;
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= S_IDLE;
      m_tvalid       <= 1'b0;
      entries_in_use <= 9'd200;
      length_limit   <= 31'h7FFF_FFFF;
    end else begin
      state <= state_next;
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_ENTRIES: entries_in_use <= cfg_data[8:0];
          REG_LIMIT:   length_limit   <= cfg_data;
          default:     ;
        endcase
      end
      if (state == S_OUT && (!m_tvalid || m_tready)) begin
        m_tvalid <= 1'b1;
      end else if (m_tvalid && m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
    case (state)
      S_IDLE: begin
        s_pos       <= in_qpos;
        h_val       <= in_qh;
        nlast       <= AW'(n_clamp - 32'd1);
        ptr         <= '0;
        force_first <= 1'b0;
        op          <= OP_INIT;
        res_status  <= ST_LIMIT;
        res_data    <= '0;
      end
      S_SFIRST: begin
        prev <= rd_data;
        ptr  <= AW'(1);
      end
      S_SCAN: begin
        if (scan_hit) begin
          cur <= rd_data;
        end else if (ptr == nlast) begin
          force_first <= 1'b1;
          ptr         <= '0;
        end else begin
          prev <= rd_data;
          ptr  <= ptr + AW'(1);
        end
      end
      S_SLOPE: begin
        tk         <= prev.tstamp;
        res_status <= ST_ZERODIV;
      end
      S_WALK: begin
        if (walk_go) begin
          prev <= cur;
          cur  <= rd_data;
          ptr  <= ptr + AW'(1);
        end
      end
      S_SEG: begin
        c_val <= sat32(66'(h_val) - (66'(prev.tstamp) - 66'(tk) - 66'(init_t)));
        op    <= OP_SPEED;
      end
      S_DWAIT: begin
        if (drsp.done) begin
          case (op)
            OP_INIT:  init_t  <= drsp.quot;
            OP_SPEED: q_speed <= drsp.quot;
            OP_ORATE: q_orate <= drsp.quot;
            OP_PPOS:  q_ppos  <= sat32(66'(prev.position) + 66'(drsp.quot));
            default: begin
              res_status <= ST_OK;
              res_data   <= {sat32(66'(prev.offset) + 66'(drsp.quot)),
                             q_orate, q_ppos, q_speed};
            end
          endcase
          if (op != OP_INIT && op != OP_POFF) begin
            op <= op_t'(op + 3'd1);
          end
        end
      end
      S_OUT: begin
        if (!m_tvalid || m_tready) begin
          m_tdata <= res_data;
          m_tuser <= res_status;
        end
      end
      default: ;
    endcase
  end

  // the scan and the walk never run past the last entry in use
  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == S_SCAN || state == S_WALK) |-> ptr <= nlast)
    else $error("table pointer beyond last entry");

  // a faulted result carries zero data
  a_fault_zero: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && m_tuser != ST_OK) |-> m_tdata == '0)
    else $error("faulted result with non-zero data");

  // divider completes only while it is awaited
  a_div_done: assert property (@(posedge clk) disable iff (rst)
    drsp.done |-> state == S_DWAIT)
    else $error("divider result outside wait state");

  // a query start leaves the idle state at once
  a_query_start: assert property (@(posedge clk) disable iff (rst)
    (in_acc && is_query) |=> state != S_IDLE)
    else $error("query accepted but not started");

endmodule

`default_nettype wire

// ===== tb/trajectory_table_interpolator_checker.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trajectory_table_interpolator_checker
// Watches the request, result and register channels of the interpolator. It
// keeps a copy of the table and the registers, works out the result of every
// accepted query and compares each returned result with the oldest expected
// one, field by field.
// ----------------------------------------------------------------------------
`default_nettype none

module trajectory_table_interpolator_checker
  import tti_pkg::*;
(
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [167:0] s_tdata,
  input  wire logic [0:0]   s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [127:0] m_tdata,
  input  wire logic [1:0]   m_tuser,
  input  wire logic         cfg_valid,
  input  wire logic         cfg_ready,
  input  wire logic [1:0]   cfg_index,
  input  wire logic [30:0]  cfg_data,
  output int                failures,
  output int                pending
);

  typedef struct packed {
    logic [31:0] speed;
    logic [31:0] pred_pos;
    logic [31:0] off_rate;
    logic [31:0] pred_off;
    logic [1:0]  status;
  } interp_t;

  int          pos_tab [DEF_TABLE_DEPTH];
  int          time_tab[DEF_TABLE_DEPTH];
  int          off_tab [DEF_TABLE_DEPTH];
  logic [8:0]  entries_reg;
  logic [30:0] limit_reg;
  interp_t     expected_q[$];

  function automatic longint clip32(longint v);
    if (v > 64'sd2147483647) return 64'sd2147483647;
    if (v < -64'sd2147483648) return -64'sd2147483648;
    return v;
  endfunction

  // work out the result of one query from the mirrored table
  function automatic interp_t interpolate(int s32, int h32);
    longint  s, h, dp0, dt0, init_t, walk, c, dp, dt, dof;
    int      n, k, e;
    interp_t r;
    r = '0;
    s = s32;
    h = h32;
    if (s >= longint'(limit_reg)) begin
      r.status = ST_LIMIT;
      return r;
    end
    n = entries_reg;
    if (n < 2) n = 2;
    if (n > DEF_TABLE_DEPTH) n = DEF_TABLE_DEPTH;
    // find the segment holding the position, first one by default
    k = 0;
    for (int i = 0; i + 1 < n; i++) begin
      if (s >= pos_tab[i] && s < pos_tab[i+1]) begin
        k = i;
        break;
      end
    end
    dp0 = clip32(longint'(pos_tab[k+1]) - pos_tab[k]);
    dt0 = clip32(longint'(time_tab[k+1]) - time_tab[k]);
    if (dp0 == 0) begin
      r.status = ST_ZERODIV;
      return r;
    end
    init_t = clip32((clip32(s - pos_tab[k]) * dt0) / dp0);
    // advance until the elapsed time reaches the horizon or the table ends
    e = k + 1;
    while (e < n - 1) begin
      walk = longint'(time_tab[e]) - time_tab[k] - init_t;
      if (!(walk < h)) break;
      e++;
    end
    dp  = clip32(longint'(pos_tab[e]) - pos_tab[e-1]);
    dof = clip32(longint'(off_tab[e]) - off_tab[e-1]);
    dt  = clip32(longint'(time_tab[e]) - time_tab[e-1]);
    if (dt == 0) begin
      r.status = ST_ZERODIV;
      return r;
    end
    c = clip32(h - (longint'(time_tab[e-1]) - time_tab[k] - init_t));
    r.speed    = 32'(clip32((dp * (64'sd1 <<< DEF_FRAC_BITS)) / dt));
    r.off_rate = 32'(clip32((dof * (64'sd1 <<< DEF_FRAC_BITS)) / dt));
    r.pred_pos = 32'(clip32(longint'(pos_tab[e-1]) + clip32((dp * c) / dt)));
    r.pred_off = 32'(clip32(longint'(off_tab[e-1]) + clip32((dof * c) / dt)));
    r.status   = ST_OK;
    return r;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    interp_t got, want;
    if (rst) begin
      entries_reg <= 9'd200;
      limit_reg   <= 31'h7FFF_FFFF;
      failures    <= 0;
      expected_q.delete();
    end else begin
      // mirror register writes
      if (cfg_valid && cfg_ready) begin
        if (cfg_index == REG_ENTRIES) entries_reg <= cfg_data[8:0];
        else if (cfg_index == REG_LIMIT) limit_reg <= cfg_data;
      end
      // take a request: loads update the table, queries add an expectation
      if (s_tvalid && s_tready) begin
        if (s_tuser[0] == OPN_LOAD) begin
          pos_tab [s_tdata[7:0]] = s_tdata[39:8];
          time_tab[s_tdata[7:0]] = s_tdata[71:40];
          off_tab [s_tdata[7:0]] = s_tdata[103:72];
        end else begin
          expected_q.insert(expected_q.size(),
                            interpolate(s_tdata[135:104], s_tdata[167:136]));
        end
      end
      // compare a returned result with the oldest expectation
      if (m_tvalid && m_tready) begin
        got = {m_tdata[31:0], m_tdata[63:32], m_tdata[95:64], m_tdata[127:96], m_tuser};
        if (expected_q.size() == 0) begin
          if (failures < 10) $display("result with none expected: %h", got);
          failures <= failures + 1;
        end else begin
          want = expected_q.pop_front();
          if (got !== want) begin
            if (failures < 10)
              $display("mismatch speed %h/%h pos %h/%h rate %h/%h off %h/%h st %0d/%0d",
                       want.speed, got.speed, want.pred_pos, got.pred_pos,
                       want.off_rate, got.off_rate, want.pred_off, got.pred_off,
                       want.status, got.status);
            failures <= failures + 1;
          end
        end
      end
    end
  end

endmodule

`default_nettype wire

// ===== tb/trajectory_table_interpolator_tb.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// trajectory_table_interpolator_tb
// Fills the table, runs directed queries on the edge cases, then random
// phases of loads and queries under several register settings, with random
// gaps on both channels. A separate checker predicts and compares.
// ----------------------------------------------------------------------------
`default_nettype none

module trajectory_table_interpolator_tb
  import tti_pkg::*;
();

  localparam int CYCLE_LIMIT = 5000000;

  logic         clk;
  logic         rst;
  logic         s_tvalid;
  logic         s_tready;
  logic [167:0] s_tdata;
  logic [0:0]   s_tuser;
  logic         m_tvalid;
  logic         m_tready;
  logic [127:0] m_tdata;
  logic [1:0]   m_tuser;
  logic         cfg_valid;
  logic         cfg_ready;
  logic [1:0]   cfg_index;
  logic [30:0]  cfg_data;
  int           failures;
  int           pending;
  int           cycles = 0;
  logic         steady;
  int           tstep;

  trajectory_table_interpolator DUT (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  trajectory_table_interpolator_checker u_checker (
    .clk(clk), .rst(rst),
    .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
    .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata), .m_tuser(m_tuser),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .failures(failures), .pending(pending)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // result side back-pressure
  always @(negedge clk) begin
    m_tready <= steady ? 1'b1 : ($urandom_range(0, 99) >= 29);
  end

  // give up on a hung run
  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("*** FAILED ***");
      $finish;
    end
  end

  // send one request, with an occasional gap before it
  task automatic send(logic op, logic [7:0] idx, int p, int t, int o, int s, int h);
    if (!steady && $urandom_range(0, 99) < 29) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 3)) @(negedge clk);
    end
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= {h, s, o, t, p, idx};
    do @(posedge clk); while (!s_tready);
  endtask

  task automatic load(logic [7:0] idx, int p, int t, int o);
    send(OPN_LOAD, idx, p, t, o, $urandom, $urandom);
  endtask

  task automatic query(int s, int h);
    send(OPN_QUERY, 8'($urandom), $urandom, $urandom, $urandom, s, h);
  endtask

  // hold off until every result is back and the block has settled
  task automatic drain();
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (pending != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  task automatic write_reg(logic [1:0] idx, logic [30:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  // one random phase: mostly well-formed rows and queries, some noise
  task automatic run_phase(int items, int n);
    int idx, s, h;
    if (n < 2) n = 2;
    if (n > 256) n = 256;
    tstep = $urandom_range(1, 32'h20000);
    for (int j = 0; j < items; j++) begin
      if ($urandom_range(0, 99) < 45) begin
        idx = $urandom_range(0, 255);
        if ($urandom_range(0, 99) < 80)
          load(8'(idx), (idx << 16) + $urandom_range(0, 32'h7FFF),
               idx * tstep + $urandom_range(0, tstep / 4), $urandom);
        else
          load(8'(idx), $urandom, $urandom, $urandom);
      end else begin
        if ($urandom_range(0, 99) < 85) begin
          s = $urandom_range(0, n * 32'h10000 + 32'h20000) - 32'h10000;
          h = $urandom_range(0, 24 * tstep) - tstep;
        end else begin
          s = $urandom;
          h = $urandom;
        end
        query(s, h);
      end
      if (j == items / 2 && $urandom_range(0, 1)) drain();
    end
    drain();
  endtask

  initial begin
    rst       = 1'b1;
    steady    = 1'b0;
    s_tvalid  = 1'b0;
    s_tdata   = '0;
    s_tuser   = OPN_LOAD;
    cfg_valid = 1'b0;
    cfg_index = REG_ENTRIES;
    cfg_data  = '0;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // fill the whole table, extremes at both ends
    for (int i = 0; i < 256; i++) begin
      if (i == 0) load(8'(i), 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
      else if (i == 255) load(8'(i), 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
      else load(8'(i), i << 16, i << 15, $urandom);
    end

    // directed queries under reset settings
    query(32'h7FFF_FFFF, 0);              // at the reset length limit
    query(32'h8000_0000, 32'h10000);      // first segment
    query(32'h0005_4000, 0);
    query(32'h0005_4000, 32'h0004_0000);
    query(32'h0005_4000, 32'h7FFF_FFFF);  // walk to the table end
    query(32'h0005_4000, 32'h8000_0000);
    query(32'h00C7_0000, 32'h0001_0000);  // on the last entry in use, held by no segment
    query(32'h7FFF_0000, 32'h0001_0000);  // beyond every entry in use
    load(8'd2, 1 << 16, 2 << 15, 0);      // flat segment after entry 1
    query(32'h0001_8000, 0);
    load(8'd2, 2 << 16, 2 << 15, 0);
    load(8'd4, 4 << 16, 3 << 15, 0);      // segment with no time span
    query(32'h0003_8000, 32'h0001_0000);
    load(8'd4, 4 << 16, 4 << 15, 0);
    drain();
    write_reg(REG_LIMIT, 31'h0003_0000);
    write_reg(2'd2, 31'h0000_0003);       // no such register
    write_reg(2'd3, 31'h7FFF_FFFF);
    query(32'h0003_0000, 0);
    query(32'h0002_FFFF, 0);
    drain();

    // random phases over several settings, one without idling
    write_reg(REG_ENTRIES, 31'd2);
    write_reg(REG_LIMIT, 31'h7FFF_FFFF);
    run_phase(110, 2);
    write_reg(REG_ENTRIES, 31'd0);
    run_phase(80, 2);
    write_reg(REG_ENTRIES, 31'd16);
    steady = 1'b1;
    run_phase(130, 16);
    steady = 1'b0;
    write_reg(REG_ENTRIES, 31'd5);
    write_reg(REG_LIMIT, 31'h0004_0000);
    run_phase(110, 5);
    write_reg(REG_ENTRIES, 31'd511);
    write_reg(REG_LIMIT, 31'h7FFF_FFFF);
    run_phase(110, 256);
    write_reg(REG_ENTRIES, 31'd256);
    write_reg(REG_LIMIT, 31'h0);
    run_phase(60, 256);
    write_reg(REG_ENTRIES, 31'd8);
    write_reg(REG_LIMIT, 31'($urandom));
    run_phase(130, 8);

    if (failures == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

`default_nettype wire

// ===== filelist.f =====
hdl/tti_pkg.sv
hdl/tti_table.sv
hdl/tti_div.sv
hdl/trajectory_table_interpolator.sv
tb/trajectory_table_interpolator_checker.sv
tb/trajectory_table_interpolator_tb.sv
